FILE: design/icli_pkg.sv
package icli_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CNT_W   = 7;
    localparam int unsigned UNIT_W  = 4;
    localparam int unsigned DELAY_W = 11;
    localparam int unsigned KIND_W  = 2;

    localparam logic [CNT_W-1:0] MAX_ARGS = 7'd127;

    localparam logic [BYTE_W-1:0] CMD_END  = 8'h00;
    localparam logic [BYTE_W-1:0] CMD_SKIP = 8'hFF;

    localparam logic [UNIT_W-1:0] UNIT_RESET = 4'd5;

    localparam logic [KIND_W-1:0] KIND_CMD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DATA  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DELAY = 2'd2;
    localparam logic [KIND_W-1:0] KIND_END   = 2'd3;

    localparam logic [1:0] PH_CMD   = 2'd0;
    localparam logic [1:0] PH_COUNT = 2'd1;
    localparam logic [1:0] PH_DATA  = 2'd2;
    localparam logic [1:0] PH_SPARE = 2'd3;

    typedef struct packed {
        logic [1:0]       phase;
        logic             skip;
        logic [CNT_W-1:0] args_left;
    } t_state;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [BYTE_W-1:0]  value;
        logic [DELAY_W-1:0] delay_ms;
        logic               last_arg;
    } t_result;

endpackage

FILE: design/icli_step.sv
module icli_step import icli_pkg::*; (
    input  t_state            i_state,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic [UNIT_W-1:0] i_unit,
    output t_state            o_state,
    output logic              o_has_result,
    output t_result           o_result
);

    logic [CNT_W-1:0]   count;
    logic [DELAY_W-1:0] delay;

    assign count = i_byte[CNT_W-1:0];
    // 7 x 4 product fits the 11-bit delay field
    assign delay = {{(DELAY_W-CNT_W){1'b0}}, count} * {{(DELAY_W-UNIT_W){1'b0}}, i_unit};

    always_comb begin
        o_state      = i_state;
        o_has_result = 1'b0;
        o_result     = '0;
        unique case (i_state.phase)
            PH_COUNT: begin
                o_state.phase = PH_CMD;
                if (i_byte[BYTE_W-1]) begin
                    o_has_result      = 1'b1;
                    o_result.kind     = KIND_DELAY;
                    o_result.delay_ms = delay;
                end else if (!i_state.skip && count != '0) begin
                    o_state.args_left = (count > MAX_ARGS) ? MAX_ARGS : count;
                    o_state.phase     = PH_DATA;
                end
            end
            PH_DATA: begin
                o_has_result   = 1'b1;
                o_result.kind  = KIND_DATA;
                o_result.value = i_byte;
                if (i_state.args_left <= 7'd1) begin
                    o_result.last_arg = 1'b1;
                    o_state.args_left = '0;
                    o_state.phase     = PH_CMD;
                end else begin
                    o_state.args_left = i_state.args_left - 7'd1;
                end
            end
            PH_CMD, PH_SPARE: begin
                if (i_byte == CMD_END) begin
                    o_state.phase = PH_CMD;
                    o_has_result  = 1'b1;
                    o_result.kind = KIND_END;
                end else if (i_byte == CMD_SKIP) begin
                    o_state.phase = PH_COUNT;
                    o_state.skip  = 1'b1;
                end else begin
                    o_state.phase  = PH_COUNT;
                    o_state.skip   = 1'b0;
                    o_has_result   = 1'b1;
                    o_result.kind  = KIND_CMD;
                    o_result.value = i_byte;
                end
            end
            default: begin
                o_state = i_state;
            end
        endcase
    end

endmodule

FILE: design/init_command_list_interpreter_top.sv
// Init command list interpreter: one list byte in, zero or one result out.
// Each result is registered in the output register, or in the skid.
// Throughput: one byte per cycle while o_stall is low; the parser state and
// the delay multiply are combinational. A sink stall on a full output register
// parks the next result in the skid; o_stall then holds input until the skid
// drains into the output register as the sink takes it.
// Reset (synchronous, i_rst_n low): parser expects a command, output empty,
// delay_unit_ms returns to 5.
module init_command_list_interpreter_top import icli_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input byte channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [BYTE_W-1:0]  i_list_byte,
    // result channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic [KIND_W-1:0]  o_kind,
    output logic [BYTE_W-1:0]  o_value,
    output logic [DELAY_W-1:0] o_delay_ms,
    output logic               o_last_arg,
    // APB config port, one register (delay_unit_ms) at address 0
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [UNIT_W-1:0] r_unit;
    t_state            r_state;
    t_state            n_state;
    logic              step_has;
    t_result           step_res;

    logic              r_out_valid;
    t_result           r_out;
    logic              r_skid_valid;
    t_result           r_skid;

    logic              in_fire;
    logic              out_fire;
    logic              out_free;

    // ---- config register ----
    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {{(32-UNIT_W){1'b0}}, r_unit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit <= UNIT_RESET;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_unit <= pwdata[UNIT_W-1:0];
        end
    end

    // ---- parser: state advances on every accepted byte ----
    icli_step u_step (
        .i_state      (r_state),
        .i_byte       (i_list_byte),
        .i_unit       (r_unit),
        .o_state      (n_state),
        .o_has_result (step_has),
        .o_result     (step_res)
    );

    // skid full means nowhere to put a new result if the sink keeps stalling
    assign o_stall  = r_skid_valid;
    assign in_fire  = i_valid && !r_skid_valid;
    assign out_fire = r_out_valid && !i_stall;
    assign out_free = out_fire || !r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: PH_CMD, skip: 1'b0, args_left: '0};
        end else if (in_fire) begin
            r_state <= n_state;
        end
    end

    // ---- output register + skid ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (out_free) begin
                if (r_skid_valid) begin
                    // skid drains first; no byte is accepted this cycle
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= in_fire && step_has;
                end
            end else if (in_fire && step_has) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : step_res;
        end
        if (!out_free && in_fire) begin
            r_skid <= step_res;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_kind     = r_out.kind;
    assign o_value    = r_out.value;
    assign o_delay_ms = r_out.delay_ms;
    assign o_last_arg = r_out.last_arg;

endmodule

FILE: design/icli_checker.sv
module icli_props import icli_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input logic [KIND_W-1:0]  o_kind,
    input logic [BYTE_W-1:0]  o_value,
    input logic [DELAY_W-1:0] o_delay_ms,
    input logic               o_last_arg
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_kind) && $stable(o_value)
            && $stable(o_delay_ms) && $stable(o_last_arg))
        else $error("stalled result changed");

    a_last_only_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind != KIND_DATA |-> !o_last_arg)
        else $error("last_arg outside data");

    a_delay_only_delay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind != KIND_DELAY |-> o_delay_ms == '0)
        else $error("delay_ms outside delay");

    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == KIND_DELAY || o_kind == KIND_END) |-> o_value == '0)
        else $error("value set on delay or end");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("output not empty after reset");

endmodule

bind init_command_list_interpreter_top icli_props u_icli_props (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_stall    (o_stall),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_kind     (o_kind),
    .o_value    (o_value),
    .o_delay_ms (o_delay_ms),
    .o_last_arg (o_last_arg)
);
